// ===== src/assert_macros.svh =====
// Assertion macros of the dense MAC requantize unit, used by dmr_ctrl.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DMR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define DMR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== src/dmr_pkg.sv =====
// Shared types and constants of the dense MAC requantize unit.
// Used by the register block, the controller, the datapath and the top level.
package dmr_pkg;

    localparam int ACC_WIDTH_DEF = 32;
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;
    localparam int MULT_W        = 31;
    localparam int SHIFT_W       = 6;

    localparam logic [1:0] REG_IN_ZP   = 2'd0;
    localparam logic [1:0] REG_OUT_ZP  = 2'd1;
    localparam logic [1:0] REG_MULT    = 2'd2;
    localparam logic [1:0] REG_SHIFT   = 2'd3;

    localparam logic [MULT_W-1:0]  MULT_RST  = 31'd1073741824;
    localparam logic [SHIFT_W-1:0] SHIFT_RST = 6'd30;

    localparam logic signed [7:0] Q_MAX = 8'sd127;
    localparam logic signed [7:0] Q_MIN = -8'sd128;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MLO  = 6'b000010,
        ST_MHI  = 6'b000100,
        ST_SUM  = 6'b001000,
        ST_RND  = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    typedef struct packed {
        logic signed [7:0]  in_zp;
        logic signed [7:0]  out_zp;
        logic [MULT_W-1:0]  mult;
        logic [SHIFT_W-1:0] shift;
    } t_cfg;

    typedef struct packed {
        logic acc_en;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic rnd;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ===== src/int8_dense_mac_requantize_unit.sv =====
// Top level of the int8 dense MAC requantize unit.
// Depends on dmr_pkg, dmr_cfg_regs, dmr_ctrl and dmr_datapath.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_stall  | activation, weight, bias, first, last
//  out     | output    | o_out_valid / i_out_stall| neuron_output
//  cfg     | input     | psel/penable/pwrite      | paddr, pwdata, prdata, pready
//
// A pair without the last flag leaves the unit idle for the next pair; its accumulate is
// a single 9x8 multiply-add. A pair with the last flag runs two split scale multiplies,
// a sum, a rounding add and the shift-and-clip that loads the output register.
// ST_FIN waits while a previous result is held by i_out_stall. Reset is synchronous,
// active low; it clears accumulator, state and out valid; config regs get reset values.
module int8_dense_mac_requantize_unit #(
    parameter int ACC_WIDTH = dmr_pkg::ACC_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [7:0]           i_activation,
    input  logic signed [7:0]           i_weight,
    input  logic signed [31:0]          i_bias,
    input  logic                        i_first_of_neuron,
    input  logic                        i_last_of_neuron,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [7:0]           o_neuron_output,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dmr_pkg::ADDR_W-1:0]  paddr,
    input  logic [dmr_pkg::DATA_W-1:0]  pwdata,
    output logic [dmr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    dmr_pkg::t_cfg w_cfg;
    dmr_pkg::t_cmd w_cmd;
    dmr_pkg::t_sts w_sts;

    dmr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dmr_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_last_of_neuron (i_last_of_neuron),
        .o_in_stall       (o_in_stall),
        .i_sts            (w_sts),
        .o_cmd            (w_cmd)
    );

    dmr_datapath #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_activation      (i_activation),
        .i_weight          (i_weight),
        .i_bias            (i_bias),
        .i_first_of_neuron (i_first_of_neuron),
        .i_cfg             (w_cfg),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_neuron_output   (o_neuron_output)
    );

endmodule

// ===== src/dmr_cfg_regs.sv =====
// APB-style configuration registers of the dense MAC requantize unit.
// Depends on dmr_pkg for register indexes, reset values and t_cfg.
module dmr_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dmr_pkg::ADDR_W-1:0]  paddr,
    input  logic [dmr_pkg::DATA_W-1:0]  pwdata,
    output logic [dmr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output dmr_pkg::t_cfg               o_cfg
);

    dmr_pkg::t_cfg r_cfg;
    logic          w_wr;
    logic [1:0]    w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_zp  <= '0;
            r_cfg.out_zp <= '0;
            r_cfg.mult   <= dmr_pkg::MULT_RST;
            r_cfg.shift  <= dmr_pkg::SHIFT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                dmr_pkg::REG_IN_ZP:  r_cfg.in_zp  <= pwdata[7:0];
                dmr_pkg::REG_OUT_ZP: r_cfg.out_zp <= pwdata[7:0];
                dmr_pkg::REG_MULT:   r_cfg.mult   <= pwdata[dmr_pkg::MULT_W-1:0];
                dmr_pkg::REG_SHIFT:  r_cfg.shift  <= pwdata[dmr_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            dmr_pkg::REG_IN_ZP:  prdata = {24'd0, r_cfg.in_zp};
            dmr_pkg::REG_OUT_ZP: prdata = {24'd0, r_cfg.out_zp};
            dmr_pkg::REG_MULT:   prdata = {1'b0, r_cfg.mult};
            dmr_pkg::REG_SHIFT:  prdata = {26'd0, r_cfg.shift};
            default:             prdata = '0;
        endcase
    end

endmodule

// ===== src/dmr_ctrl.sv =====
// Sequencing state machine of the dense MAC requantize unit.
// Depends on dmr_pkg for t_state, t_cmd and t_sts, and on assert_macros.svh.
`include "assert_macros.svh"

module dmr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last_of_neuron,
    output logic          o_in_stall,
    input  dmr_pkg::t_sts i_sts,
    output dmr_pkg::t_cmd o_cmd
);

    dmr_pkg::t_state r_state;
    dmr_pkg::t_state n_state;

    assign o_in_stall = (r_state != dmr_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            dmr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.acc_en = 1'b1;
                    if (i_last_of_neuron) begin
                        n_state = dmr_pkg::ST_MLO;
                    end
                end
            end
            dmr_pkg::ST_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = dmr_pkg::ST_MHI;
            end
            dmr_pkg::ST_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = dmr_pkg::ST_SUM;
            end
            dmr_pkg::ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = dmr_pkg::ST_RND;
            end
            dmr_pkg::ST_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = dmr_pkg::ST_FIN;
            end
            dmr_pkg::ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = dmr_pkg::ST_IDLE;
                end
            end
            default: n_state = dmr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dmr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `DMR_ASSERT_NEXT(a_last_starts_requant, i_in_valid && !o_in_stall && i_last_of_neuron, r_state == dmr_pkg::ST_MLO)
    `DMR_ASSERT_NEXT(a_plain_stays_idle, i_in_valid && !o_in_stall && !i_last_of_neuron, r_state == dmr_pkg::ST_IDLE)
    `DMR_ASSERT_NOW(a_load_only_when_free, o_cmd.load_out, i_sts.out_free && r_state == dmr_pkg::ST_FIN)

endmodule

// ===== src/dmr_datapath.sv =====
// Accumulator, split scale multiply, rounding shift, clip and output register.
// Depends on dmr_pkg for t_cfg, t_cmd, t_sts and the clip limits.
module dmr_datapath #(
    parameter int ACC_WIDTH = dmr_pkg::ACC_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [7:0]  i_activation,
    input  logic signed [7:0]  i_weight,
    input  logic signed [31:0] i_bias,
    input  logic               i_first_of_neuron,
    input  dmr_pkg::t_cfg      i_cfg,
    input  dmr_pkg::t_cmd      i_cmd,
    output dmr_pkg::t_sts      o_sts,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic signed [7:0]  o_neuron_output
);

    localparam int LO_W = ACC_WIDTH / 2;
    localparam int HI_W = ACC_WIDTH - LO_W;
    localparam int MW   = dmr_pkg::MULT_W;
    localparam int PLW  = LO_W + MW;
    localparam int PHW  = HI_W + MW + 1;
    localparam int VW   = ACC_WIDTH + 48;

    logic [ACC_WIDTH-1:0]    r_acc;
    logic [PLW-1:0]          r_plo;
    logic signed [PHW-1:0]   r_phi;
    logic signed [VW-1:0]    r_v;
    logic                    r_out_valid;
    logic signed [7:0]       r_out;

    logic signed [8:0]       w_diff;
    logic signed [16:0]      w_prod;
    logic [ACC_WIDTH-1:0]    w_base;
    logic [PLW-1:0]          w_plo;
    logic signed [PHW-1:0]   w_phi;
    logic signed [VW-1:0]    w_zsh;
    logic [VW-1:0]           w_mask;
    logic signed [VW-1:0]    w_q;
    logic signed [7:0]       w_clip;

    assign w_diff = 9'(i_activation) - 9'(i_cfg.in_zp);
    assign w_prod = 17'(w_diff) * 17'(i_weight);
    assign w_base = i_first_of_neuron ? ACC_WIDTH'(i_bias) : r_acc;

    assign w_plo  = PLW'(r_acc[LO_W-1:0]) * PLW'(i_cfg.mult);
    assign w_phi  = PHW'($signed(r_acc[ACC_WIDTH-1:LO_W])) * PHW'($signed({1'b0, i_cfg.mult}));
    assign w_zsh  = VW'(i_cfg.out_zp) <<< i_cfg.shift;
    assign w_mask = (VW'(1) << i_cfg.shift) - VW'(1);
    assign w_q    = r_v >>> i_cfg.shift;

    always_comb begin
        if (w_q > VW'(dmr_pkg::Q_MAX)) begin
            w_clip = dmr_pkg::Q_MAX;
        end else if (w_q < VW'(dmr_pkg::Q_MIN)) begin
            w_clip = dmr_pkg::Q_MIN;
        end else begin
            w_clip = w_q[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= w_base + ACC_WIDTH'(w_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo) begin
            r_plo <= w_plo;
        end
        if (i_cmd.mul_hi) begin
            r_phi <= w_phi;
            r_v   <= $signed(VW'(r_plo)) + w_zsh;
        end else if (i_cmd.sum) begin
            r_v   <= r_v + (VW'(r_phi) <<< LO_W);
        end else if (i_cmd.rnd) begin
            r_v   <= r_v + (r_v[VW-1] ? $signed(w_mask) : $signed(VW'(0)));
        end
        if (i_cmd.load_out) begin
            r_out <= w_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_neuron_output = r_out;

endmodule
